// ----- sv/nkpl_pkg.sv -----
// ============================================================================
// nkpl_pkg: shared types and constants of the nearest point list
// Operation, reply and status codes, register indexes, controller states and
// the command and status bundles between controller and datapath.
// ============================================================================
package nkpl_pkg;

  // Fixed field widths.
  localparam int RAD_W     = 25;
  localparam int CAP_W     = 5;
  localparam int RANK_W    = 4;
  localparam int TOTAL_W   = 5;
  localparam int OP_W      = 2;
  localparam int KIND_W    = 2;
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 2;

  // Register reset values.
  localparam logic [RAD_W-1:0] RADIUS_RST = 25'd1;
  localparam logic [CAP_W-1:0] CAP_RST    = 5'd16;

  // Input operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_OFFER = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // Reply kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_OFFER = 2'd1,
    KIND_ENTRY = 2'd2
  } kind_t;

  // Offer outcome codes.
  typedef enum logic [ST_W-1:0] {
    ST_INSERTED   = 2'd0,
    ST_OUTSIDE    = 2'd1,
    ST_DUPLICATE  = 2'd2,
    ST_NOT_RANKED = 2'd3
  } offer_st_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Z = 2'd1,
    REG_RADIUS   = 2'd2,
    REG_CAPACITY = 2'd3
  } cfg_reg_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RAD,
    S_SCAN_PT,
    S_SCAN_ENT,
    S_DRAIN,
    S_DECIDE,
    S_SHIFT_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_RESP_OFFER,
    S_RESP_CLEAR,
    S_RESP_EMPTY,
    S_RD_ADDR,
    S_RD_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic issue_rad;
    logic issue_pt;
    logic issue_ent;
    logic decide;
    logic shift_rd;
    logic shift_wr;
    logic ins_wr;
    logic load_clear;
    logic load_offer;
    logic load_entry;
    logic load_empty;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;
    logic ent_more;
    logic pipe_empty;
    logic ins_ok;
    logic shift_more;
    logic out_free;
    logic rd_last;
  } dp_status_t;

endpackage

// ----- sv/nearest_k_point_list.sv -----
// Offer: scans the stored points, then decides; an insert also shifts each entry
// below the insert point down. The scan pipeline takes one entry a cycle.
// Read-out emits the entries one at a time.
// One operation at a time; a new item is taken while the last result still waits.
// Reset clears count, result register and registers to defaults; the store is not
// cleared (no clearing pass), entries beyond the count are never read.
// ============================================================================
// nearest_k_point_list: sorted list of the points nearest to a center
// Keeps up to a configured number of points ordered by squared distance,
// with tie breaks on x then z, and answers clear, offer and read-out.
// ============================================================================
module nearest_k_point_list #(
  parameter int MAX_ENTRIES = 16,
  parameter int COORD_BITS  = 26,
  localparam int IW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int IN_DW  = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_DW = ((12 + 2 * COORD_BITS + 7) / 8) * 8,
  localparam int CFG_W  = (COORD_BITS > nkpl_pkg::RAD_W) ? COORD_BITS : nkpl_pkg::RAD_W,
  localparam int MEM_W  = 2 * COORD_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration write port
  input  logic                           cfg_we,
  input  logic [nkpl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]               cfg_wdata,
  // Input channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [IN_DW-1:0]               in_tdata,   // point_x, point_z
  input  logic [nkpl_pkg::OP_W-1:0]      in_tuser,   // operation
  // Result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // offer_status, entry_valid, entry_rank, entry_x, entry_z, entry_total
  output logic [OUT_DW-1:0]              out_tdata,
  output logic [nkpl_pkg::KIND_W-1:0]    out_tuser,  // reply_kind
  output logic                           out_tlast
);
  import nkpl_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t sts;

  logic             ram_we;
  logic [IW-1:0]    ram_waddr, ram_raddr;
  logic [MEM_W-1:0] ram_wdata, ram_rdata;

  // Sequencer.
  nkpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath.
  nkpl_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .cmd        (cmd),
    .sts        (sts)
  );

  // Entry store, x in the low half and z in the high half.
  nkpl_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- sv/nkpl_ram.sv -----
// ============================================================================
// nkpl_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ============================================================================
module nkpl_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/nkpl_ctrl.sv -----
// ============================================================================
// nkpl_ctrl: sequencer of the nearest point list
// Steps each operation through scan, decision, shift, insert and reply, and
// paces the read-out one entry at a time.
// ============================================================================
module nkpl_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [nkpl_pkg::OP_W-1:0] in_tuser,
  input  nkpl_pkg::dp_status_t      sts,
  output nkpl_pkg::ctl_cmd_t        cmd
);
  import nkpl_pkg::*;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          unique case (op_t'(in_tuser))
            OP_CLEAR: state_nxt = S_RESP_CLEAR;
            OP_OFFER: state_nxt = S_SCAN_RAD;
            OP_READ:  state_nxt = sts.cnt_zero ? S_RESP_EMPTY : S_RD_ADDR;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN_RAD: begin
        cmd.issue_rad = 1'b1;
        state_nxt     = S_SCAN_PT;
      end
      S_SCAN_PT: begin
        cmd.issue_pt = 1'b1;
        state_nxt    = S_SCAN_ENT;
      end
      S_SCAN_ENT: begin
        if (sts.ent_more) begin
          cmd.issue_ent = 1'b1;
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.pipe_empty) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = sts.ins_ok ? S_SHIFT_CHK : S_RESP_OFFER;
      end
      S_SHIFT_CHK: begin
        state_nxt = sts.shift_more ? S_SHIFT_RD : S_INSERT;
      end
      S_SHIFT_RD: begin
        cmd.shift_rd = 1'b1;
        state_nxt    = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = S_SHIFT_CHK;
      end
      S_INSERT: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = S_RESP_OFFER;
      end
      S_RESP_OFFER: begin
        if (sts.out_free) begin
          cmd.load_offer = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_RESP_CLEAR: begin
        if (sts.out_free) begin
          cmd.load_clear = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_RESP_EMPTY: begin
        if (sts.out_free) begin
          cmd.load_empty = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_RD_ADDR: begin
        state_nxt = S_RD_EMIT;
      end
      S_RD_EMIT: begin
        if (sts.out_free) begin
          cmd.load_entry = 1'b1;
          state_nxt      = sts.rd_last ? S_IDLE : S_RD_ADDR;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- sv/nkpl_dp.sv -----
// ============================================================================
// nkpl_dp: datapath of the nearest point list
// Holds configuration, entry count and the result register, runs the
// pipelined distance and compare scan, and drives the entry store.
// ============================================================================
module nkpl_dp #(
  parameter int MAX_ENTRIES = 16,
  parameter int COORD_BITS  = 26,
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1),
  localparam int IW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int IN_DW  = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_DW = ((12 + 2 * COORD_BITS + 7) / 8) * 8,
  localparam int CFG_W  = (COORD_BITS > nkpl_pkg::RAD_W) ? COORD_BITS : nkpl_pkg::RAD_W,
  localparam int MEM_W  = 2 * COORD_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration writes
  input  logic                           cfg_we,
  input  logic [nkpl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]               cfg_wdata,
  // Input payload
  input  logic [IN_DW-1:0]               in_tdata,
  // Result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_DW-1:0]              out_tdata,
  output logic [nkpl_pkg::KIND_W-1:0]    out_tuser,
  output logic                           out_tlast,
  // Entry store
  output logic                           ram_we,
  output logic [IW-1:0]                  ram_waddr,
  output logic [MEM_W-1:0]               ram_wdata,
  output logic [IW-1:0]                  ram_raddr,
  input  logic [MEM_W-1:0]               ram_rdata,
  // Controller link
  input  nkpl_pkg::ctl_cmd_t             cmd,
  output nkpl_pkg::dp_status_t           sts
);
  import nkpl_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int MW = (CB > RAD_W) ? CB : RAD_W;
  localparam int DW = 2 * MW + 1;
  localparam int CW = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // What a scan slot carries through the distance pipeline.
  typedef enum logic [1:0] {
    TAG_RAD,
    TAG_PT,
    TAG_ENT
  } tag_t;

  // Configuration and list state.
  logic signed [CB-1:0] cx_r, cz_r;
  logic [RAD_W-1:0]     rad_r;
  logic [CAP_W-1:0]     cap_r;
  logic [CNT_W-1:0]     cnt_r;

  // Offered point and counters.
  logic signed [CB-1:0] px_r, pz_r;
  logic [CNT_W-1:0]     ix_r;
  logic [IW-1:0]        j_r;

  // Scan pipeline.
  logic          s0_v_r, s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  tag_t          s0_tag_r, s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r;
  logic [IW-1:0] s0_idx_r, s1_idx_r, s2_idx_r, s3_idx_r, s4_idx_r;
  logic [MW-1:0] s1_dx_r, s1_dz_r, s2_dz_r;
  logic [2*MW-1:0] s2_sqx_r, s3_sqx_r, s3_sqz_r;
  logic [DW-1:0] s4_dist_r;
  logic          s1_eq_r, s2_eq_r, s3_eq_r, s4_eq_r;
  logic          s1_tie_r, s2_tie_r, s3_tie_r, s4_tie_r;

  // Scan results.
  logic [DW-1:0] rad2_r, pd_r;
  logic          dup_r, found_r, ahead_last_r;
  logic [IW-1:0] pos_r;

  // Decision results.
  offer_st_t     st_r;
  logic [CNT_W-1:0] ins_pos_r, newn_r;

  // Result register.
  logic               out_v_r;
  kind_t              o_kind_r;
  logic [ST_W-1:0]    o_st_r;
  logic               o_valid_r;
  logic [RANK_W-1:0]  o_rank_r;
  logic [CB-1:0]      o_x_r, o_z_r;
  logic [TOTAL_W-1:0] o_total_r;
  logic               o_last_r;

  // Stage one: absolute coordinate differences and point-versus-entry tests.
  logic signed [CB-1:0] ex, ez, ax, az;
  logic signed [CB:0]   dfx, dfz;
  logic [CB-1:0]        adx, adz;
  logic [MW-1:0]        dx1, dz1;
  logic                 eq1, tie1;

  always_comb begin
    ex  = signed'(ram_rdata[CB-1:0]);
    ez  = signed'(ram_rdata[2*CB-1:CB]);
    ax  = (s0_tag_r == TAG_ENT) ? ex : px_r;
    az  = (s0_tag_r == TAG_ENT) ? ez : pz_r;
    dfx = signed'({ax[CB-1], ax}) - signed'({cx_r[CB-1], cx_r});
    dfz = signed'({az[CB-1], az}) - signed'({cz_r[CB-1], cz_r});
    adx = dfx[CB] ? CB'(-dfx) : dfx[CB-1:0];
    adz = dfz[CB] ? CB'(-dfz) : dfz[CB-1:0];
    if (s0_tag_r == TAG_RAD) begin
      dx1 = MW'(rad_r);
      dz1 = '0;
    end else begin
      dx1 = MW'(adx);
      dz1 = MW'(adz);
    end
    eq1  = (ram_rdata == {pz_r, px_r});
    tie1 = (px_r < ex) || ((px_r == ex) && (pz_r < ez));
  end

  // Final stage: does the offered point rank ahead of this entry.
  logic ahead4;
  assign ahead4 = (pd_r < s4_dist_r) || ((pd_r == s4_dist_r) && s4_tie_r);

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s0_v_r <= cmd.issue_rad | cmd.issue_pt | cmd.issue_ent;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  // Pipeline payload: issue, differences, two squares, sum.
  always_ff @(posedge clk) begin
    if (cmd.issue_rad) begin
      s0_tag_r <= TAG_RAD;
    end else if (cmd.issue_pt) begin
      s0_tag_r <= TAG_PT;
    end else begin
      s0_tag_r <= TAG_ENT;
    end
    s0_idx_r  <= ix_r[IW-1:0];
    s1_tag_r  <= s0_tag_r;
    s1_idx_r  <= s0_idx_r;
    s1_dx_r   <= dx1;
    s1_dz_r   <= dz1;
    s1_eq_r   <= eq1;
    s1_tie_r  <= tie1;
    s2_tag_r  <= s1_tag_r;
    s2_idx_r  <= s1_idx_r;
    s2_sqx_r  <= s1_dx_r * s1_dx_r;
    s2_dz_r   <= s1_dz_r;
    s2_eq_r   <= s1_eq_r;
    s2_tie_r  <= s1_tie_r;
    s3_tag_r  <= s2_tag_r;
    s3_idx_r  <= s2_idx_r;
    s3_sqx_r  <= s2_sqx_r;
    s3_sqz_r  <= s2_dz_r * s2_dz_r;
    s3_eq_r   <= s2_eq_r;
    s3_tie_r  <= s2_tie_r;
    s4_tag_r  <= s3_tag_r;
    s4_idx_r  <= s3_idx_r;
    s4_dist_r <= DW'(s3_sqx_r) + DW'(s3_sqz_r);
    s4_eq_r   <= s3_eq_r;
    s4_tie_r  <= s3_tie_r;
  end

  // Scan accumulation: radius limit, point distance, duplicate and rank.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dup_r        <= 1'b0;
      found_r      <= 1'b0;
      ahead_last_r <= 1'b0;
      pos_r        <= '0;
    end else if (s4_v_r) begin
      unique case (s4_tag_r)
        TAG_RAD: rad2_r <= s4_dist_r;
        TAG_PT:  pd_r   <= s4_dist_r;
        TAG_ENT: begin
          if (s4_eq_r) begin
            dup_r <= 1'b1;
          end
          if (ahead4 && !found_r) begin
            found_r <= 1'b1;
            pos_r   <= s4_idx_r;
          end
          if (CNT_W'(s4_idx_r) == cnt_r - 1'b1) begin
            ahead_last_r <= ahead4;
          end
        end
        default: ;
      endcase
    end
  end

  // Effective capacity and the offer decision.
  logic [CW-1:0]    cap_w;
  logic [CNT_W-1:0] cap_eff, pos_eff, newn;
  logic             full;
  offer_st_t        st_dec;

  always_comb begin
    cap_w = CW'(cap_r);
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_w > CW'(MAX_ENTRIES)) begin
      cap_eff = CNT_W'(MAX_ENTRIES);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
    pos_eff = found_r ? CNT_W'(pos_r) : cnt_r;
    full    = (cnt_r >= cap_eff);
    newn    = full ? cnt_r : cnt_r + 1'b1;
    priority if (pd_r > rad2_r) begin
      st_dec = ST_OUTSIDE;
    end else if (full && (cnt_r != '0) && !ahead_last_r) begin
      st_dec = ST_NOT_RANKED;
    end else if (dup_r) begin
      st_dec = ST_DUPLICATE;
    end else if (pos_eff >= cap_eff) begin
      st_dec = ST_NOT_RANKED;
    end else begin
      st_dec = ST_INSERTED;
    end
  end

  // Input latch, counters and decision registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_r <= signed'(in_tdata[CB-1:0]);
      pz_r <= signed'(in_tdata[2*CB-1:CB]);
      ix_r <= '0;
    end else if (cmd.issue_ent || cmd.load_entry) begin
      ix_r <= ix_r + 1'b1;
    end
    if (cmd.decide) begin
      st_r      <= st_dec;
      ins_pos_r <= pos_eff;
      newn_r    <= newn;
      j_r       <= IW'(newn - 1'b1);
    end else if (cmd.shift_wr) begin
      j_r <= j_r - 1'b1;
    end
  end

  // Configuration registers and entry count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cz_r  <= '0;
      rad_r <= RADIUS_RST;
      cap_r <= CAP_RST;
      cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_CENTER_X: cx_r  <= signed'(cfg_wdata[CB-1:0]);
          REG_CENTER_Z: cz_r  <= signed'(cfg_wdata[CB-1:0]);
          REG_RADIUS:   rad_r <= cfg_wdata[RAD_W-1:0];
          REG_CAPACITY: cap_r <= cfg_wdata[CAP_W-1:0];
        endcase
      end
      priority if (cfg_we && (cfg_reg_t'(cfg_index) == REG_CAPACITY)) begin
        cnt_r <= '0;
      end else if (cmd.load_clear) begin
        cnt_r <= '0;
      end else if (cmd.ins_wr) begin
        cnt_r <= newn_r;
      end
    end
  end

  // Entry store access: shift moves one entry down, insert writes the point.
  assign ram_raddr = cmd.shift_rd ? j_r - 1'b1 : ix_r[IW-1:0];
  assign ram_we    = cmd.shift_wr | cmd.ins_wr;
  assign ram_waddr = cmd.ins_wr ? ins_pos_r[IW-1:0] : j_r;
  assign ram_wdata = cmd.ins_wr ? {pz_r, px_r} : ram_rdata;

  // Result register; it frees up in the cycle its transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (cmd.load_clear || cmd.load_offer || cmd.load_entry || cmd.load_empty) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_clear || cmd.load_offer || cmd.load_entry || cmd.load_empty) begin
      o_st_r    <= ST_W'(ST_INSERTED);
      o_valid_r <= 1'b0;
      o_rank_r  <= '0;
      o_x_r     <= '0;
      o_z_r     <= '0;
      o_total_r <= TOTAL_W'(cnt_r);
      o_last_r  <= 1'b1;
      if (cmd.load_clear) begin
        o_kind_r  <= KIND_CLEAR;
        o_total_r <= '0;
      end else if (cmd.load_offer) begin
        o_kind_r <= KIND_OFFER;
        o_st_r   <= ST_W'(st_r);
      end else if (cmd.load_entry) begin
        o_kind_r  <= KIND_ENTRY;
        o_valid_r <= 1'b1;
        o_rank_r  <= RANK_W'(ix_r);
        o_x_r     <= ram_rdata[CB-1:0];
        o_z_r     <= ram_rdata[2*CB-1:CB];
        o_last_r  <= sts.rd_last;
      end else begin
        o_kind_r <= KIND_ENTRY;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = KIND_W'(o_kind_r);
  assign out_tlast  = o_last_r;
  assign out_tdata  = OUT_DW'({o_total_r, o_z_r, o_x_r, o_rank_r, o_valid_r, o_st_r});

  // Status to the controller.
  always_comb begin
    sts.cnt_zero   = (cnt_r == '0);
    sts.ent_more   = (ix_r < cnt_r);
    sts.pipe_empty = !(s0_v_r | s1_v_r | s2_v_r | s3_v_r | s4_v_r);
    sts.ins_ok     = (st_dec == ST_INSERTED);
    sts.shift_more = (CNT_W'(j_r) > ins_pos_r);
    sts.out_free   = !out_v_r || out_tready;
    sts.rd_last    = ((ix_r + 1'b1) == cnt_r);
  end

endmodule

// ----- sv/nkpl_checker.sv -----
// ============================================================================
// nkpl_checker: port-level checks of the nearest point list
// Watches the channel ports over time; bound to the top level below.
// ============================================================================
module nkpl_checker #(
  parameter int COORD_BITS = 26,
  localparam int OUT_DW = ((12 + 2 * COORD_BITS + 7) / 8) * 8,
  localparam int TOT_LO = 7 + 2 * COORD_BITS
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [nkpl_pkg::OP_W-1:0]   in_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [OUT_DW-1:0]           out_tdata,
  input logic [nkpl_pkg::KIND_W-1:0] out_tuser,
  input logic                        out_tlast
);
  import nkpl_pkg::*;

  // Reset empties the result register.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result transfer holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // A valid operation keeps the input closed in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready &&
      ((in_tuser == OP_CLEAR) || (in_tuser == OP_OFFER) || (in_tuser == OP_READ))
      |=> !in_tready)
    else $error("input taken while an operation runs");

  // Clear and offer replies are single results.
  a_single_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == KIND_CLEAR) || (out_tuser == KIND_OFFER)) |-> out_tlast)
    else $error("clear or offer reply without last");

  // An entry reply without a point only comes from an empty list.
  a_empty_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_ENTRY) && !out_tdata[2] |->
      out_tlast && (out_tdata[TOT_LO+4:TOT_LO] == 5'd0))
    else $error("empty entry reply on a non-empty list");

endmodule

bind nearest_k_point_list nkpl_checker #(.COORD_BITS(COORD_BITS)) u_nkpl_checker (.*);

// ----- tb/sv/nearest_k_point_list_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// nearest_k_point_list_tb: self-checking bench for the nearest point list
// Streams clear, offer and read-out commands through the input channel in
// random bursts. A cycle-free predictor of the sorted list builds the expected
// replies. Each reply is checked field by field against the oldest expected
// reply. Register settings change only between drained phases.
// ============================================================================
module nearest_k_point_list_tb;
  import nkpl_pkg::*;

  localparam int                 CW             = 26;
  localparam int                 DEPTH          = 16;
  localparam logic [OP_W-1:0]    OP_UNUSED      = 2'd3;
  localparam int                 LATENCY_GAP    = 100;
  localparam int                 HOLD_CYCLES    = 300;
  localparam int                 WATCHDOG_LIMIT = 3000;
  localparam int                 MAX_REPORTS    = 100;
  localparam int                 COORD_MIN      = -33554432;
  localparam int                 COORD_MAX      = 33554431;
  localparam int                 RADIUS_MAX     = 33554431;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_PERIODIC
  } rdy_mode_t;

  // One command for the input channel.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [CW-1:0]   x;
    logic [CW-1:0]   z;
  } cmd_t;

  // One reply as the result channel should carry it.
  typedef struct {
    kind_t         kind;
    offer_st_t     status;
    logic          valid;
    logic [3:0]    rank;
    logic [CW-1:0] x;
    logic [CW-1:0] z;
    logic [4:0]    total;
    logic          last;
  } reply_t;

  // DUT connections, all driven from time zero.
  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CW-1:0]        cfg_wdata  = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [55:0]          in_tdata   = '0;  // point_x, point_z
  logic [OP_W-1:0]      in_tuser   = '0;  // operation
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // offer_status, entry_valid, entry_rank, entry_x, entry_z, entry_total
  logic [63:0]          out_tdata;
  logic [KIND_W-1:0]    out_tuser;  // reply_kind
  logic                 out_tlast;

  // Predictor copy of the registers and the sorted list.
  logic signed [CW-1:0] ctr_x   = '0;
  logic signed [CW-1:0] ctr_z   = '0;
  logic [RAD_W-1:0]     rad     = RADIUS_RST;
  logic [CAP_W-1:0]     cap_reg = CAP_RST;
  logic signed [CW-1:0] list_x [DEPTH];
  logic signed [CW-1:0] list_z [DEPTH];
  int                   list_count = 0;

  // Bench bookkeeping.
  cmd_t          cmd_q[$];
  reply_t        reply_q[$];
  logic [CW-1:0] seen_x[$];
  logic [CW-1:0] seen_z[$];
  int            queued_cnt  = 0;
  int            taken_cnt   = 0;
  int            err_cnt     = 0;
  int            gap_left    = 0;
  int            burst_left  = 0;
  int            hold_req    = 0;
  int            hold_ack    = 0;
  int            hold_left   = 0;
  int            mode_left   = 0;
  int            stall_tick  = 0;
  int            idle_cycles = 0;
  rdy_mode_t     ready_mode  = RDY_ALWAYS;

  nearest_k_point_list i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Squared distance to the center; fits easily in 64 bits at these widths.
  function automatic logic [63:0] sq_dist(logic signed [CW-1:0] x, logic signed [CW-1:0] z);
    longint dx;
    longint dz;
    dx = longint'(x) - longint'(ctr_x);
    dz = longint'(z) - longint'(ctr_z);
    if (dx < 0) dx = -dx;
    if (dz < 0) dz = -dz;
    return 64'(dx * dx + dz * dz);
  endfunction

  // True when the point sorts strictly ahead of list entry k.
  function automatic logic ranks_ahead(logic signed [CW-1:0] x, logic signed [CW-1:0] z, int k);
    logic [63:0] d_pt;
    logic [63:0] d_ent;
    d_pt  = sq_dist(x, z);
    d_ent = sq_dist(list_x[k], list_z[k]);
    if (d_pt != d_ent) return d_pt < d_ent;
    return (x < list_x[k]) || (x == list_x[k] && z < list_z[k]);
  endfunction

  // Capacity as the block applies it: zero acts as one, large values saturate.
  function automatic int eff_cap();
    if (cap_reg == '0) return 1;
    if (int'(cap_reg) > DEPTH) return DEPTH;
    return int'(cap_reg);
  endfunction

  // Offer a point to the list and return the outcome.
  function automatic offer_st_t offer_point(logic signed [CW-1:0] x, logic signed [CW-1:0] z);
    int          cap;
    int          n;
    int          pos;
    int          newn;
    logic [63:0] lim;
    cap = eff_cap();
    n   = list_count;
    lim = {39'd0, rad} * {39'd0, rad};
    if (sq_dist(x, z) > lim) return ST_OUTSIDE;
    // A full list rejects anything not ahead of its last entry, duplicates included.
    if (n >= cap && n > 0 && !ranks_ahead(x, z, n - 1)) return ST_NOT_RANKED;
    for (int i = 0; i < n; i++) begin
      if (list_x[i] == x && list_z[i] == z) return ST_DUPLICATE;
    end
    pos = 0;
    while (pos < n && !ranks_ahead(x, z, pos)) pos++;
    if (pos >= cap) return ST_NOT_RANKED;
    newn = (n < cap) ? n + 1 : n;
    for (int i = newn - 1; i > pos; i--) begin
      list_x[i] = list_x[i - 1];
      list_z[i] = list_z[i - 1];
    end
    list_x[pos] = x;
    list_z[pos] = z;
    list_count  = newn;
    return ST_INSERTED;
  endfunction

  function automatic reply_t make_reply(kind_t kind, offer_st_t st, logic valid,
                                        logic [3:0] rank, logic [CW-1:0] x,
                                        logic [CW-1:0] z, logic last);
    reply_t r;
    r.kind   = kind;
    r.status = st;
    r.valid  = valid;
    r.rank   = rank;
    r.x      = x;
    r.z      = z;
    r.total  = 5'(list_count);
    r.last   = last;
    return r;
  endfunction

  // Update the list for one accepted command and queue its replies.
  task automatic apply_request(logic [OP_W-1:0] op, logic [CW-1:0] x, logic [CW-1:0] z);
    offer_st_t st;
    case (op)
      OP_CLEAR: begin
        list_count = 0;
        reply_q.push_back(make_reply(KIND_CLEAR, ST_INSERTED, 1'b0, 4'd0, '0, '0, 1'b1));
      end
      OP_OFFER: begin
        st = offer_point(x, z);
        reply_q.push_back(make_reply(KIND_OFFER, st, 1'b0, 4'd0, '0, '0, 1'b1));
      end
      OP_READ: begin
        // An empty list still answers with one invalid entry.
        if (list_count == 0) begin
          reply_q.push_back(make_reply(KIND_ENTRY, ST_INSERTED, 1'b0, 4'd0, '0, '0, 1'b1));
        end else begin
          for (int k = 0; k < list_count; k++) begin
            reply_q.push_back(make_reply(KIND_ENTRY, ST_INSERTED, 1'b1, 4'(k),
                                         list_x[k], list_z[k], k == list_count - 1));
          end
        end
      end
      default: begin
        // The unused code is dropped without a reply.
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Input driver: bursts of transfers separated by random gaps.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cmd_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_request(in_tuser, in_tdata[CW-1:0], in_tdata[2*CW-1:CW]);
        taken_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          nxt = cmd_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= nxt.op;
          in_tdata  <= {4'd0, nxt.z, nxt.x};
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result ready: changing stall patterns, plus a long hold-off on request.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        ready_mode = rdy_mode_t'($urandom_range(2));
        mode_left  = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      stall_tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (ready_mode)
          RDY_ALWAYS: out_tready <= 1'b1;
          RDY_RANDOM: out_tready <= ($urandom_range(1) == 1);
          default:    out_tready <= (stall_tick % 5 != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reply_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: unexpected reply, expected none, actual kind %0h data %0h",
                   $time, out_tuser, out_tdata);
      end else begin
        want = reply_q.pop_front();
        check_field("reply_kind", 64'(want.kind), 64'(out_tuser));
        check_field("offer_status", 64'(want.status), 64'(out_tdata[1:0]));
        check_field("entry_valid", 64'(want.valid), 64'(out_tdata[2]));
        check_field("entry_rank", 64'(want.rank), 64'(out_tdata[6:3]));
        check_field("entry_x", 64'(want.x), 64'(out_tdata[32:7]));
        check_field("entry_z", 64'(want.z), 64'(out_tdata[58:33]));
        check_field("entry_total", 64'(want.total), 64'(out_tdata[63:59]));
        check_field("last", 64'(want.last), 64'(out_tlast));
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_cmd(logic [OP_W-1:0] op, logic [CW-1:0] x, logic [CW-1:0] z);
    cmd_t c;
    c.op = op;
    c.x  = x;
    c.z  = z;
    cmd_q.push_back(c);
    queued_cnt++;
  endtask

  task automatic add_offer(int x, int z);
    seen_x.push_back(CW'(x));
    seen_z.push_back(CW'(z));
    add_cmd(OP_OFFER, CW'(x), CW'(z));
  endtask

  function automatic logic [CW-1:0] rand26();
    return CW'($urandom());
  endfunction

  function automatic int rand_center();
    return int'($urandom_range(60000000)) - 30000000;
  endfunction

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Register write, applied to the predictor at the same time.
  task automatic write_reg(cfg_reg_t idx, int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CW'(val);
    case (idx)
      REG_CENTER_X: ctr_x = CW'(val);
      REG_CENTER_Z: ctr_z = CW'(val);
      REG_RADIUS:   rad   = RAD_W'(val);
      default: begin
        cap_reg    = CAP_W'(val);
        list_count = 0;
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(int cx, int cz, int radius_v, int cap_v);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_RADIUS, radius_v);
    write_reg(REG_CAPACITY, cap_v);
    @(negedge clk);
  endtask

  // Wait until every command is taken and every reply has arrived, then let
  // the block finish any command that has no reply.
  task automatic wait_drained();
    do @(negedge clk); while (taken_cnt != queued_cnt || reply_q.size() != 0);
    repeat (LATENCY_GAP) @(negedge clk);
  endtask

  // Random commands, most of them offers around the current center.
  task automatic gen_random(int n);
    int unsigned pick;
    int unsigned span;
    int          k;
    longint      px;
    longint      pz;
    span = int'(rad) + int'(rad) / 8 + 2;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        add_cmd(OP_CLEAR, rand26(), rand26());
      end else if (pick < 22) begin
        add_cmd(OP_READ, rand26(), rand26());
      end else if (pick < 26) begin
        add_cmd(OP_UNUSED, rand26(), rand26());
      end else if (pick < 38 && seen_x.size() > 0) begin
        k = $urandom_range(seen_x.size() - 1);
        add_cmd(OP_OFFER, seen_x[k], seen_z[k]);
      end else if (pick < 46) begin
        add_offer(int'($signed(rand26())), int'($signed(rand26())));
      end else begin
        px = longint'(ctr_x) + longint'($urandom_range(2 * span)) - longint'(span);
        pz = longint'(ctr_z) + longint'($urandom_range(2 * span)) - longint'(span);
        add_offer(int'(px), int'(pz));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: unit radius around the origin, sixteen entries.
    add_cmd(OP_READ, '0, '0);
    add_offer(0, 0);
    add_offer(1, 0);
    add_offer(0, 1);
    add_offer(-1, 0);
    add_offer(0, -1);
    add_offer(1, 1);
    add_offer(0, 0);
    add_offer(COORD_MIN, COORD_MAX);
    add_offer(COORD_MAX, COORD_MIN);
    add_cmd(OP_UNUSED, '1, '1);
    add_cmd(OP_READ, '0, '0);
    add_cmd(OP_CLEAR, '0, '0);
    add_cmd(OP_READ, '0, '0);
    wait_drained();

    // Center at the coordinate extremes, two entries: full-list rejection,
    // a repeat of the last entry, eviction and a distance tie.
    apply_setting(COORD_MIN, COORD_MAX, RADIUS_MAX, 2);
    add_offer(COORD_MIN, COORD_MAX);
    add_offer(COORD_MIN + 3, COORD_MAX);
    add_offer(COORD_MIN + 5, COORD_MAX);
    add_offer(COORD_MIN + 3, COORD_MAX);
    add_offer(COORD_MIN + 1, COORD_MAX);
    add_offer(COORD_MIN, COORD_MAX);
    add_offer(COORD_MIN, COORD_MAX - 1);
    add_offer(COORD_MAX, COORD_MIN);
    add_cmd(OP_READ, '0, '0);
    wait_drained();

    // Zero radius with capacity zero, which acts as one.
    apply_setting(1234, -5678, 0, 0);
    add_offer(1235, -5678);
    add_offer(1234, -5678);
    add_offer(1234, -5678);
    add_cmd(OP_READ, '0, '0);
    wait_drained();

    // Random phases over several settings.
    seen_x.delete();
    seen_z.delete();
    apply_setting(rand_center(), rand_center(), rand_between(3, 8), 4);
    gen_random(19);
    wait_drained();

    // Widest radius and a full list, with one long stall of the result side.
    seen_x.delete();
    seen_z.delete();
    apply_setting(rand_center(), rand_center(), RADIUS_MAX, 16);
    hold_req++;
    gen_random(19);
    wait_drained();

    seen_x.delete();
    seen_z.delete();
    apply_setting(rand_center(), rand_center(), rand_between(1000, RADIUS_MAX), 31);
    gen_random(19);
    wait_drained();

    seen_x.delete();
    seen_z.delete();
    apply_setting(rand_center(), rand_center(), 2, 1);
    gen_random(19);
    wait_drained();

    seen_x.delete();
    seen_z.delete();
    apply_setting(rand_center(), rand_center(), rand_between(1, RADIUS_MAX),
                  rand_between(1, 16));
    gen_random(19);
    wait_drained();

    // Anything still expected at this point never arrived.
    if (reply_q.size() != 0) begin
      err_cnt += reply_q.size();
      $display("%0t: %0d expected replies never arrived", $time, reply_q.size());
    end
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
